>>> design/aps_pkg.sv
// Shared types and sizes for the arrival/priority schedule timing block.
// Used by the sort chain, the request queue, the scheduler and the top level.
package aps_pkg;
  localparam int MAX_PROCESSES = 64;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [6:0]  number;
  } rec_t;

  // One scheduled request handed from the front to the back.
  typedef struct packed {
    rec_t rec;
    logic ovf;
    logic first;
    logic last;
  } sched_req_t;
endpackage

>>> design/arrival_priority_schedule_timing.sv
// Top level of the non-preemptive priority schedule timing block.
// Depends on aps_pkg, aps_sort_chain, aps_queue and aps_sched.
//
// Push one process record per cycle while full is low; each record is
// numbered from 1 in load order and dropped if 64 are already held, which
// sets overflow_flag on every result of that set. Each record is placed
// into a register chain sorted by arrival then priority, equal keys
// staying in load order. The record marked last ends the set; full then
// stays high while the chain drains in schedule order, one request per
// cycle while the queue has room, through a two-entry queue into the timing
// stage, which emits one result per cycle while pop keeps up. The results
// of a set follow its last record; the next set is taken once the chain
// has drained. The first result starts at its own arrival, later ones at
// the later of the previous finish and their arrival.
module arrival_priority_schedule_timing import aps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] arrival_time,
  input  logic [15:0] burst_time,
  input  logic [7:0]  prio_level,
  input  logic        last_process,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  process_number,
  output logic [15:0] arrival_out,
  output logic [21:0] waiting_time,
  output logic [22:0] turnaround_time,
  output logic        overflow_flag,
  output logic        last_result
);
  logic q_push, q_full, q_rd, q_empty;
  sched_req_t q_in, q_out;
  logic [CNT_W-1:0] count_mon;

  // Front: load, sort, drain
  aps_sort_chain u_front (
    .clk, .rst, .push, .full, .arrival_time, .burst_time, .prio_level,
    .last_process, .q_push, .q_full, .q_data(q_in), .count_mon
  );

  // Hold sorted requests between front and back
  aps_queue u_queue (
    .clk, .rst, .wr(q_push), .wr_data(q_in), .q_full,
    .rd(q_rd), .q_empty, .rd_data(q_out)
  );

  // Back: time each request and hold the result
  aps_sched u_back (
    .clk, .rst, .q_empty, .q_data(q_out), .q_rd, .empty, .pop,
    .process_number, .arrival_out, .waiting_time, .turnaround_time,
    .overflow_flag, .last_result
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_mon <= CNT_W'(MAX_PROCESSES))
    else $error("record count beyond capacity");

  a_no_queue_overrun: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request pushed into full queue");

  a_tat_ge_wait: assert property (@(posedge clk) disable iff (rst)
    !empty |-> turnaround_time >= 23'(waiting_time))
    else $error("turnaround below waiting time");
endmodule

>>> design/aps_sort_chain.sv
// Front part: loads records into a chain kept sorted on (arrival, priority),
// then drains it in order into the request queue. Depends on aps_pkg.
module aps_sort_chain import aps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] arrival_time,
  input  logic [15:0] burst_time,
  input  logic [7:0]  prio_level,
  input  logic        last_process,
  output logic        q_push,
  input  logic        q_full,
  output sched_req_t  q_data,
  output logic [CNT_W-1:0] count_mon
);
  typedef enum logic {LOAD, DRAIN} state_t;
  state_t state;
  rec_t cells [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] valid;
  logic [MAX_PROCESSES-1:0] le;
  logic [MAX_PROCESSES:0] le_ext;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] remaining;
  logic dropped, drain_ovf, first;
  logic room, accept, drain;
  logic [23:0] new_key;

  assign room = (count < CNT_W'(MAX_PROCESSES));
  assign accept = push && (state == LOAD);
  assign drain = (state == DRAIN) && !q_full;
  assign full = (state == DRAIN);
  assign new_key = {arrival_time, prio_level};
  assign count_mon = count;

  always_comb begin
    for (int i = 0; i < MAX_PROCESSES; i++)
      le[i] = valid[i] && ({cells[i].arrival, cells[i].prio} <= new_key);
  end

  // bit i holds the compare of the cell in front of cell i; the head sees a match
  assign le_ext = {le, 1'b1};

  assign q_push = drain;
  assign q_data = '{rec: cells[0], ovf: drain_ovf, first: first,
                    last: (remaining == CNT_W'(1))};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      valid <= '0;
      count <= '0;
      remaining <= '0;
      dropped <= 1'b0;
      drain_ovf <= 1'b0;
      first <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (accept) begin
            if (room) begin
              // insert behind every equal key to keep load order
              for (int i = 0; i < MAX_PROCESSES; i++) begin
                if (!le[i] && le_ext[i]) begin
                  cells[i] <= '{arrival: arrival_time, burst: burst_time,
                                prio: prio_level, number: 7'(count + 1'b1)};
                  valid[i] <= 1'b1;
                end
              end
              // shift every larger key one place back
              for (int i = 1; i < MAX_PROCESSES; i++) begin
                if (valid[i-1] && !le[i-1]) begin
                  cells[i] <= cells[i-1];
                  valid[i] <= 1'b1;
                end
              end
            end
            if (last_process) begin
              state <= DRAIN;
              first <= 1'b1;
              drain_ovf <= dropped || !room;
              remaining <= room ? CNT_W'(count + 1'b1) : count;
            end else begin
              if (room) count <= CNT_W'(count + 1'b1);
              else dropped <= 1'b1;
            end
          end
        end
        DRAIN: begin
          if (drain) begin
            // advance the chain toward its head
            for (int i = 0; i < MAX_PROCESSES - 1; i++) begin
              cells[i] <= cells[i+1];
              valid[i] <= valid[i+1];
            end
            valid[MAX_PROCESSES-1] <= 1'b0;
            first <= 1'b0;
            remaining <= CNT_W'(remaining - 1'b1);
            if (remaining == CNT_W'(1)) begin
              state <= LOAD;
              count <= '0;
              dropped <= 1'b0;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end
endmodule

>>> design/aps_queue.sv
// Two-entry request queue between the front and the back part.
// Depends on aps_pkg for the request type.
module aps_queue import aps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  sched_req_t wr_data,
  output logic       q_full,
  input  logic       rd,
  output logic       q_empty,
  output sched_req_t rd_data
);
  sched_req_t mem [2];
  logic wp, rp;
  logic [1:0] level;

  assign q_full = (level == 2'd2);
  assign q_empty = (level == 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !q_full) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      level <= '0;
    end else begin
      if (wr && !q_full) wp <= ~wp;
      if (rd && !q_empty) rp <= ~rp;
      level <= 2'(level + (wr && !q_full) - (rd && !q_empty));
    end
  end
endmodule

>>> design/aps_sched.sv
// Back part: runs sorted requests one after another and holds one timed result.
// Depends on aps_pkg.
module aps_sched import aps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  sched_req_t  q_data,
  output logic        q_rd,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  process_number,
  output logic [15:0] arrival_out,
  output logic [21:0] waiting_time,
  output logic [22:0] turnaround_time,
  output logic        overflow_flag,
  output logic        last_result
);
  logic out_valid;
  logic [22:0] finish_time;
  logic [22:0] start, arr23;
  logic [22:0] wait_full;

  assign empty = !out_valid;
  assign q_rd = !q_empty && (!out_valid || pop);
  assign arr23 = 23'(q_data.rec.arrival);
  assign start = (q_data.first || finish_time < arr23) ? arr23 : finish_time;
  assign wait_full = start - arr23;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      process_number <= q_data.rec.number;
      arrival_out <= q_data.rec.arrival;
      waiting_time <= wait_full[21:0];
      turnaround_time <= 23'(wait_full + 23'(q_data.rec.burst));
      overflow_flag <= q_data.ovf;
      last_result <= q_data.last;
    end
    if (rst) begin
      out_valid <= 1'b0;
      finish_time <= '0;
    end else begin
      if (q_rd) begin
        out_valid <= 1'b1;
        finish_time <= 23'(start + 23'(q_data.rec.burst));
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
